### design/mtp_pkg.sv
// ----------------------------------------------------------------------------
// Move-to-pose controller package
// Request and response types, fixed-point constants, register indexes and
// the arithmetic helpers shared by the controller core.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

   localparam int CORDIC_ITER_DEFAULT = 16;
   localparam int MUL_BITS = 32;
   localparam int PROD_W = 68;
   localparam int CORDIC_W = 36;

   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] W_SCALE = 32'd105414357;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
   localparam logic [31:0] BEARING_ROUND = 32'h0000_8000;

   localparam logic signed [PROD_W-1:0] SAT_MAX = 68'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_MIN = -68'sd2147483648;

   localparam logic [1:0] OP_SET_GOAL = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_LOAD_START = 2'd2;

   localparam logic [2:0] REG_GAIN_DISTANCE = 3'd0;
   localparam logic [2:0] REG_GAIN_BEARING = 3'd1;
   localparam logic [2:0] REG_GAIN_FINAL_HEADING = 3'd2;
   localparam logic [2:0] REG_TIME_STEP = 3'd3;
   localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd4;
   localparam logic [2:0] REG_START_X = 3'd5;
   localparam logic [2:0] REG_START_Y = 3'd6;
   localparam logic [2:0] REG_START_HEADING = 3'd7;

   localparam logic [15:0] RESET_GAIN = 16'd256;
   localparam logic [15:0] RESET_TIME_STEP = 16'd6554;
   localparam logic [31:0] RESET_ARRIVE_RADIUS = 32'd6554;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
      logic [31:0]        distance;
      logic               arrived;
   } rsp_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      case (idx)
         5'd0: atan_turn = 32'h2000_0000;
         5'd1: atan_turn = 32'h12E4_051E;
         5'd2: atan_turn = 32'h09FB_385B;
         5'd3: atan_turn = 32'h0511_11D4;
         5'd4: atan_turn = 32'h028B_0D43;
         5'd5: atan_turn = 32'h0145_D7E1;
         5'd6: atan_turn = 32'h00A2_F61E;
         5'd7: atan_turn = 32'h0051_7C55;
         5'd8: atan_turn = 32'h0028_BE53;
         5'd9: atan_turn = 32'h0014_5F2F;
         5'd10: atan_turn = 32'h000A_2F98;
         5'd11: atan_turn = 32'h0005_17CC;
         5'd12: atan_turn = 32'h0002_8BE6;
         5'd13: atan_turn = 32'h0001_45F3;
         5'd14: atan_turn = 32'h0000_A2F9;
         5'd15: atan_turn = 32'h0000_517C;
         5'd16: atan_turn = 32'h0000_28BE;
         5'd17: atan_turn = 32'h0000_145F;
         5'd18: atan_turn = 32'h0000_0A2F;
         5'd19: atan_turn = 32'h0000_0517;
         5'd20: atan_turn = 32'h0000_028B;
         5'd21: atan_turn = 32'h0000_0145;
         5'd22: atan_turn = 32'h0000_00A2;
         5'd23: atan_turn = 32'h0000_0051;
         default: atan_turn = 32'h0000_0000;
      endcase
   endfunction

   // Rounds v / 2^s to nearest with ties away from zero.
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v, input int unsigned s);
      logic signed [PROD_W-1:0] half;
      logic signed [PROD_W-1:0] adj;
      half = 68'sd1 <<< (s - 1);
      adj = $signed({67'd0, v[PROD_W-1]});
      round_shift = (v + half - adj) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > SAT_MAX) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

`default_nettype wire

### design/move_to_pose_controller_core.sv
// ----------------------------------------------------------------------------
// Move-to-pose controller core
// Polar pose controller for a unicycle robot with a bit-serial multiplier,
// an iterative CORDIC and a two-bit-per-cycle square root.
// ----------------------------------------------------------------------------
// One request is in flight at a time; req_stall is high whenever the core is
// not idle. The serial multiplier is used up to eleven times per step.
// Reset is synchronous and active high; it restores the register defaults
// and clears pose and goal.
`default_nettype none

module move_to_pose_controller_core
   import mtp_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int IW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_PREP = 5'd1;
   localparam logic [4:0] S_VEC = 5'd2;
   localparam logic [4:0] S_SQX = 5'd3;
   localparam logic [4:0] S_SQY = 5'd4;
   localparam logic [4:0] S_SQRT = 5'd5;
   localparam logic [4:0] S_DEC = 5'd6;
   localparam logic [4:0] S_MGB = 5'd7;
   localparam logic [4:0] S_MGF = 5'd8;
   localparam logic [4:0] S_MRHO = 5'd9;
   localparam logic [4:0] S_MW = 5'd10;
   localparam logic [4:0] S_MTS = 5'd11;
   localparam logic [4:0] S_ROT = 5'd12;
   localparam logic [4:0] S_ISC = 5'd13;
   localparam logic [4:0] S_MVC = 5'd14;
   localparam logic [4:0] S_MRX = 5'd15;
   localparam logic [4:0] S_MVS = 5'd16;
   localparam logic [4:0] S_MRY = 5'd17;
   localparam logic [4:0] S_OUT = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;

   logic [15:0] gain_dist_ff, gain_dist_in, gain_bear_ff, gain_bear_in;
   logic [15:0] gain_fin_ff, gain_fin_in, time_step_ff, time_step_in;
   logic [31:0] arrive_ff, arrive_in;
   logic signed [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [15:0] start_h_ff, start_h_in;

   logic signed [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic signed [31:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [15:0] pose_h_ff, pose_h_in, goal_h_ff, goal_h_in;

   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0] cz_ff, cz_in;
   logic [IW-1:0] ci_ff, ci_in;
   logic vzero_ff, vzero_in;
   logic [15:0] bear_ff, bear_in;

   logic signed [PROD_W-1:0] mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [MUL_BITS-1:0] mul_b_ff, mul_b_in;
   logic [5:0] mul_cnt_ff, mul_cnt_in;

   logic [31:0] ay_ff, ay_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] sr_n_ff, sr_n_in;
   logic [35:0] sr_rem_ff, sr_rem_in;
   logic [31:0] sr_root_ff, sr_root_in;
   logic [4:0] sr_cnt_ff, sr_cnt_in;
   logic sr_sat_ff, sr_sat_in;

   logic [31:0] rho_ff, rho_in;
   logic arrived_ff, arrived_in;
   logic signed [15:0] alpha_ff, alpha_in, beta_ff, beta_in;
   logic signed [33:0] d_ff, d_in;
   logic signed [31:0] v_ff, v_in, w_ff, w_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic mul_go;
   logic signed [PROD_W-1:0] mul_ld_a;
   logic signed [CORDIC_W-1:0] mul_ld_b, mul_bmag;
   logic mul_done;

   logic signed [CORDIC_W-1:0] sh_x, sh_y, cx_n, cy_n;
   logic [31:0] cz_n, atan_w, bear_z;
   logic sig_p, ypos, c_last;

   logic [35:0] rem_sh, trial, rem_n;
   logic [31:0] root_n;
   logic sq_ge;

   logic signed [32:0] dx_w, dy_w, ax_w, ay_w;
   logic signed [CORDIC_W-1:0] dx36, dy36;
   logic [64:0] sum_w;
   logic [15:0] alpha_w, beta_w, ph_w;
   logic signed [PROD_W-1:0] rnd_w, pv_w;
   logic [31:0] pv32, zrot;
   logic vneg;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign mul_done = (mul_cnt_ff == 6'd0);

   always_comb begin
      sh_x = cx_ff >>> ci_ff;
      sh_y = cy_ff >>> ci_ff;
      atan_w = atan_turn(5'(ci_ff));
      ypos = !cy_ff[CORDIC_W-1] && (cy_ff != '0);
      sig_p = (state_ff == S_VEC) ? !ypos : !cz_ff[31];
      cx_n = sig_p ? cx_ff - sh_y : cx_ff + sh_y;
      cy_n = sig_p ? cy_ff + sh_x : cy_ff - sh_x;
      cz_n = sig_p ? cz_ff - atan_w : cz_ff + atan_w;
      c_last = (ci_ff == IW'(CORDIC_ITERATIONS - 1));
      bear_z = cz_n + BEARING_ROUND;

      rem_sh = {sr_rem_ff[33:0], sr_n_ff[63:62]};
      trial = {2'b00, sr_root_ff, 2'b01};
      sq_ge = (rem_sh >= trial);
      rem_n = sq_ge ? rem_sh - trial : rem_sh;
      root_n = {sr_root_ff[30:0], sq_ge};

      dx_w = $signed({goal_x_ff[31], goal_x_ff}) - $signed({pose_x_ff[31], pose_x_ff});
      dy_w = $signed({goal_y_ff[31], goal_y_ff}) - $signed({pose_y_ff[31], pose_y_ff});
      ax_w = dx_w[32] ? -dx_w : dx_w;
      ay_w = dy_w[32] ? -dy_w : dy_w;
      dx36 = {{(CORDIC_W-33){dx_w[32]}}, dx_w};
      dy36 = {{(CORDIC_W-33){dy_w[32]}}, dy_w};
      sum_w = {1'b0, sq_ff} + {1'b0, mul_p_ff[63:0]};
      alpha_w = bear_ff - pose_h_ff;
      beta_w = goal_h_ff - pose_h_ff - alpha_w;
      rnd_w = '0;
      pv_w = (mul_p_ff + 68'sd128) >>> 8;
      pv32 = (pv_w > SAT_MAX) ? 32'h7FFF_FFFF : pv_w[31:0];
      vneg = (alpha_ff > 16'sd16384) || (alpha_ff < -16'sd16384);
      ph_w = '0;
      zrot = '0;

      state_in = state_ff;
      op_in = op_ff;
      gain_dist_in = gain_dist_ff;
      gain_bear_in = gain_bear_ff;
      gain_fin_in = gain_fin_ff;
      time_step_in = time_step_ff;
      arrive_in = arrive_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      start_h_in = start_h_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      pose_h_in = pose_h_ff;
      goal_h_in = goal_h_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      ci_in = ci_ff;
      vzero_in = vzero_ff;
      bear_in = bear_ff;
      ay_in = ay_ff;
      sq_in = sq_ff;
      sr_n_in = sr_n_ff;
      sr_rem_in = sr_rem_ff;
      sr_root_in = sr_root_ff;
      sr_cnt_in = sr_cnt_ff;
      sr_sat_in = sr_sat_ff;
      rho_in = rho_ff;
      arrived_in = arrived_ff;
      alpha_in = alpha_ff;
      beta_in = beta_ff;
      d_in = d_ff;
      v_in = v_ff;
      w_in = w_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      mul_go = 1'b0;
      mul_ld_a = '0;
      mul_ld_b = '0;

      if (csr_we) begin
         case (csr_addr)
            REG_GAIN_DISTANCE: gain_dist_in = csr_wdata[15:0];
            REG_GAIN_BEARING: gain_bear_in = csr_wdata[15:0];
            REG_GAIN_FINAL_HEADING: gain_fin_in = csr_wdata[15:0];
            REG_TIME_STEP: time_step_in = csr_wdata[15:0];
            REG_ARRIVE_RADIUS: arrive_in = csr_wdata;
            REG_START_X: start_x_in = csr_wdata;
            REG_START_Y: start_y_in = csr_wdata;
            REG_START_HEADING: start_h_in = csr_wdata[15:0];
            default: arrive_in = arrive_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.op;
               if (req_data.op == OP_SET_GOAL) begin
                  goal_x_in = req_data.target_x;
                  goal_y_in = req_data.target_y;
               end else if (req_data.op == OP_LOAD_START) begin
                  pose_x_in = start_x_ff;
                  pose_y_in = start_y_ff;
                  pose_h_in = start_h_ff;
                  goal_x_in = start_x_ff;
                  goal_y_in = start_y_ff;
                  goal_h_in = start_h_ff;
               end
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            vzero_in = (dx_w == '0) && (dy_w == '0);
            ay_in = ay_w[31:0];
            if (dx_w[32]) begin
               if (!dy_w[32]) begin
                  cx_in = dy36;
                  cy_in = -dx36;
                  cz_in = QUARTER_TURN;
               end else begin
                  cx_in = -dy36;
                  cy_in = dx36;
                  cz_in = THREE_QUARTER_TURN;
               end
            end else begin
               cx_in = dx36;
               cy_in = dy36;
               cz_in = '0;
            end
            ci_in = '0;
            mul_go = 1'b1;
            mul_ld_a = {35'd0, ax_w};
            mul_ld_b = {3'd0, ax_w};
            state_in = S_VEC;
         end
         S_VEC: begin
            cx_in = cx_n;
            cy_in = cy_n;
            cz_in = cz_n;
            ci_in = ci_ff + 1'b1;
            if (c_last) begin
               bear_in = vzero_ff ? 16'd0 : bear_z[31:16];
               if (op_ff == OP_SET_GOAL) begin
                  goal_h_in = vzero_ff ? 16'd0 : bear_z[31:16];
               end
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            if (mul_done) begin
               sq_in = mul_p_ff[63:0];
               mul_go = 1'b1;
               mul_ld_a = {36'd0, ay_ff};
               mul_ld_b = {4'd0, ay_ff};
               state_in = S_SQY;
            end
         end
         S_SQY: begin
            if (mul_done) begin
               sr_n_in = sum_w[63:0];
               sr_sat_in = sum_w[64];
               sr_rem_in = '0;
               sr_root_in = '0;
               sr_cnt_in = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            sr_rem_in = rem_n;
            sr_root_in = root_n;
            sr_n_in = {sr_n_ff[61:0], 2'b00};
            sr_cnt_in = sr_cnt_ff + 5'd1;
            if (sr_cnt_ff == 5'd31) begin
               rho_in = sr_sat_ff ? 32'hFFFF_FFFF : root_n;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            arrived_in = (rho_ff <= arrive_ff);
            if ((op_ff != OP_STEP) || (rho_ff <= arrive_ff)) begin
               v_in = '0;
               w_in = '0;
               state_in = S_OUT;
            end else begin
               alpha_in = alpha_w;
               beta_in = beta_w;
               mul_go = 1'b1;
               mul_ld_a = {{52{alpha_w[15]}}, alpha_w};
               mul_ld_b = {20'd0, gain_bear_ff};
               state_in = S_MGB;
            end
         end
         S_MGB: begin
            if (mul_done) begin
               d_in = mul_p_ff[33:0];
               mul_go = 1'b1;
               mul_ld_a = {{52{beta_ff[15]}}, beta_ff};
               mul_ld_b = {20'd0, gain_fin_ff};
               state_in = S_MGF;
            end
         end
         S_MGF: begin
            if (mul_done) begin
               d_in = d_ff - mul_p_ff[33:0];
               mul_go = 1'b1;
               mul_ld_a = {36'd0, rho_ff};
               mul_ld_b = {20'd0, gain_dist_ff};
               state_in = S_MRHO;
            end
         end
         S_MRHO: begin
            if (mul_done) begin
               v_in = vneg ? -$signed(pv32) : $signed(pv32);
               mul_go = 1'b1;
               mul_ld_a = {{34{d_ff[33]}}, d_ff};
               mul_ld_b = {4'd0, W_SCALE};
               state_in = S_MW;
            end
         end
         S_MW: begin
            if (mul_done) begin
               w_in = sat32(round_shift(mul_p_ff, 32));
               mul_go = 1'b1;
               mul_ld_a = {{34{d_ff[33]}}, d_ff};
               mul_ld_b = {20'd0, time_step_ff};
               state_in = S_MTS;
            end
         end
         S_MTS: begin
            if (mul_done) begin
               rnd_w = round_shift(mul_p_ff, 24);
               ph_w = pose_h_ff + rnd_w[15:0];
               pose_h_in = ph_w;
               zrot = {ph_w, 16'd0};
               cy_in = '0;
               ci_in = '0;
               if ((zrot > QUARTER_TURN) && (zrot < THREE_QUARTER_TURN)) begin
                  cx_in = -$signed({4'd0, CORDIC_GAIN_Q30});
                  cz_in = zrot - HALF_TURN;
               end else begin
                  cx_in = $signed({4'd0, CORDIC_GAIN_Q30});
                  cz_in = zrot;
               end
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            cx_in = cx_n;
            cy_in = cy_n;
            cz_in = cz_n;
            ci_in = ci_ff + 1'b1;
            if (c_last) begin
               state_in = S_ISC;
            end
         end
         S_ISC: begin
            mul_go = 1'b1;
            mul_ld_a = {{36{v_ff[31]}}, v_ff};
            mul_ld_b = cx_ff;
            state_in = S_MVC;
         end
         S_MVC: begin
            if (mul_done) begin
               mul_go = 1'b1;
               mul_ld_a = round_shift(mul_p_ff, 30);
               mul_ld_b = {20'd0, time_step_ff};
               state_in = S_MRX;
            end
         end
         S_MRX: begin
            if (mul_done) begin
               rnd_w = round_shift(mul_p_ff, 16);
               pose_x_in = sat32({{36{pose_x_ff[31]}}, pose_x_ff} + rnd_w);
               mul_go = 1'b1;
               mul_ld_a = {{36{v_ff[31]}}, v_ff};
               mul_ld_b = cy_ff;
               state_in = S_MVS;
            end
         end
         S_MVS: begin
            if (mul_done) begin
               mul_go = 1'b1;
               mul_ld_a = round_shift(mul_p_ff, 30);
               mul_ld_b = {20'd0, time_step_ff};
               state_in = S_MRY;
            end
         end
         S_MRY: begin
            if (mul_done) begin
               rnd_w = round_shift(mul_p_ff, 16);
               pose_y_in = sat32({{36{pose_y_ff[31]}}, pose_y_ff} + rnd_w);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.linear_velocity = v_ff;
               rsp_in.angular_velocity = w_ff;
               rsp_in.distance = rho_ff;
               rsp_in.arrived = arrived_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      mul_bmag = mul_ld_b[CORDIC_W-1] ? -mul_ld_b : mul_ld_b;
      if (mul_go) begin
         mul_a_in = mul_ld_b[CORDIC_W-1] ? -mul_ld_a : mul_ld_a;
         mul_b_in = mul_bmag[MUL_BITS-1:0];
         mul_p_in = '0;
         mul_cnt_in = 6'(MUL_BITS);
      end else if (!mul_done) begin
         mul_a_in = mul_a_ff <<< 1;
         mul_b_in = mul_b_ff >> 1;
         mul_p_in = mul_b_ff[0] ? mul_p_ff + mul_a_ff : mul_p_ff;
         mul_cnt_in = mul_cnt_ff - 6'd1;
      end else begin
         mul_a_in = mul_a_ff;
         mul_b_in = mul_b_ff;
         mul_p_in = mul_p_ff;
         mul_cnt_in = mul_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_cnt_ff <= '0;
         gain_dist_ff <= RESET_GAIN;
         gain_bear_ff <= RESET_GAIN;
         gain_fin_ff <= RESET_GAIN;
         time_step_ff <= RESET_TIME_STEP;
         arrive_ff <= RESET_ARRIVE_RADIUS;
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_h_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         goal_h_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_cnt_ff <= mul_cnt_in;
         gain_dist_ff <= gain_dist_in;
         gain_bear_ff <= gain_bear_in;
         gain_fin_ff <= gain_fin_in;
         time_step_ff <= time_step_in;
         arrive_ff <= arrive_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         start_h_ff <= start_h_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         pose_h_ff <= pose_h_in;
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         goal_h_ff <= goal_h_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      ci_ff <= ci_in;
      vzero_ff <= vzero_in;
      bear_ff <= bear_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mul_p_ff <= mul_p_in;
      ay_ff <= ay_in;
      sq_ff <= sq_in;
      sr_n_ff <= sr_n_in;
      sr_rem_ff <= sr_rem_in;
      sr_root_ff <= sr_root_in;
      sr_cnt_ff <= sr_cnt_in;
      sr_sat_ff <= sr_sat_in;
      rho_ff <= rho_in;
      arrived_ff <= arrived_in;
      alpha_ff <= alpha_in;
      beta_ff <= beta_in;
      d_ff <= d_in;
      v_ff <= v_in;
      w_ff <= w_in;
      rsp_ff <= rsp_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PREP))
      else $error("accepted request did not start processing");

   a_arrived_still: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.arrived) |->
         (rsp_data.linear_velocity == 0 && rsp_data.angular_velocity == 0))
      else $error("velocity commanded inside the arrive radius");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      mul_cnt_ff <= 6'(MUL_BITS))
      else $error("multiplier count out of range");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_OUT))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

### tb/sv/move_to_pose_controller_core_tb.sv
// ----------------------------------------------------------------------------
// Move-to-pose controller core testbench
// Drives set-goal, step, load-start and unused-op requests through the
// valid/stall channel with random gaps and response stalls. It also walks the
// register file through reset, extreme and random settings. Every response is
// checked field by field against a fixed-point predictor of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_pose_controller_core_tb;
   import mtp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CORDIC_STEPS = 16;
   localparam int SETTLE_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint INT32_MAX = 64'sd2147483647;
   localparam longint INT32_MIN = -64'sd2147483648;
   localparam logic [31:0] ATAN_TABLE [0:15] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   rsp_type expected_responses[$];
   int      error_count;
   longint  cycle_count;
   bit      no_gaps;

   longint     k_distance, k_bearing, k_heading, step_time, arrive_limit;
   longint     start_px, start_py, pose_px, pose_py, goal_px, goal_py;
   logic [15:0] start_hd, pose_hd, goal_hd;

   move_to_pose_controller_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(input longint v);
      if (v > INT32_MAX) return INT32_MAX;
      if (v < INT32_MIN) return INT32_MIN;
      return v;
   endfunction

   function automatic longint round_div(input longint v, input int s);
      longint half;
      half = 64'sd1 <<< (s - 1);
      if (v < 0) return -(((-v) + half) >>> s);
      return (v + half) >>> s;
   endfunction

   function automatic logic [31:0] root_of(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] range_to_goal(input longint dx, input longint dy);
      logic [63:0] ax, ay, sx, sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sx = ax * ax;
      sy = ay * ay;
      if (sx > ~64'd0 - sy) return 32'hFFFF_FFFF;
      return root_of(sx + sy);
   endfunction

   function automatic logic [15:0] heading_to(input longint dx, input longint dy);
      longint x, y, nx, ny, t;
      logic [31:0] z;
      logic [31:0] r;
      z = 0;
      x = dx;
      y = dy;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = QUARTER_TURN;
         end else begin
            x = -y; y = t; z = THREE_QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TABLE[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TABLE[i];
         end
         x = nx;
         y = ny;
      end
      r = (z + 32'h8000) >> 16;
      return r[15:0];
   endfunction

   task automatic rotate_unit(input logic [15:0] ang, output longint c, output longint s);
      logic [31:0] z;
      longint x, y, nx, ny;
      z = {ang, 16'h0000};
      x = longint'(CORDIC_GAIN_Q30);
      y = 0;
      if (z > QUARTER_TURN && z < THREE_QUARTER_TURN) begin
         x = -x;
         z = z - HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z < HALF_TURN) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TABLE[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TABLE[i];
         end
         x = nx;
         y = ny;
      end
      c = x;
      s = y;
   endtask

   task automatic predict_command(input req_type r, output rsp_type e);
      longint v, w, d, dh, c, s, pv;
      logic [31:0] rho;
      logic [15:0] bear;
      logic signed [15:0] a16, b16;
      logic [15:0] newh;
      bit reached;
      v = 0;
      w = 0;
      if (r.op == OP_SET_GOAL) begin
         goal_px = longint'(r.target_x);
         goal_py = longint'(r.target_y);
         goal_hd = heading_to(goal_px - pose_px, goal_py - pose_py);
      end else if (r.op == OP_LOAD_START) begin
         pose_px = start_px; pose_py = start_py; pose_hd = start_hd;
         goal_px = start_px; goal_py = start_py; goal_hd = start_hd;
      end
      rho = range_to_goal(goal_px - pose_px, goal_py - pose_py);
      reached = longint'(rho) <= arrive_limit;
      if (r.op == OP_STEP && !reached) begin
         bear = heading_to(goal_px - pose_px, goal_py - pose_py);
         a16 = bear - pose_hd;
         b16 = goal_hd - pose_hd - a16;
         d = k_bearing * longint'(a16) - k_heading * longint'(b16);
         pv = (longint'(rho) * k_distance + 128) >>> 8;
         if (pv > INT32_MAX) pv = INT32_MAX;
         v = (a16 > 16384 || a16 < -16384) ? -pv : pv;
         w = clamp32(round_div(d * longint'(W_SCALE), 32));
         dh = round_div(d * step_time, 24);
         newh = pose_hd + dh[15:0];
         pose_hd = newh;
         rotate_unit(pose_hd, c, s);
         pose_px = clamp32(pose_px + round_div(round_div(v * c, 30) * step_time, 16));
         pose_py = clamp32(pose_py + round_div(round_div(v * s, 30) * step_time, 16));
      end
      e.linear_velocity = v[31:0];
      e.angular_velocity = w[31:0];
      e.distance = rho;
      e.arrived = reached;
   endtask

   task automatic apply_defaults();
      k_distance = 256; k_bearing = 256; k_heading = 256;
      step_time = 6554; arrive_limit = 6554;
      start_px = 0; start_py = 0; start_hd = 0;
      pose_px = 0; pose_py = 0; pose_hd = 0;
      goal_px = 0; goal_py = 0; goal_hd = 0;
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      case (idx)
         REG_GAIN_DISTANCE: k_distance = value[15:0];
         REG_GAIN_BEARING: k_bearing = value[15:0];
         REG_GAIN_FINAL_HEADING: k_heading = value[15:0];
         REG_TIME_STEP: step_time = value[15:0];
         REG_ARRIVE_RADIUS: arrive_limit = value;
         REG_START_X: start_px = longint'($signed(value));
         REG_START_Y: start_py = longint'($signed(value));
         default: start_hd = value[15:0];
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(input logic [15:0] gd, input logic [15:0] gb,
                            input logic [15:0] gh, input logic [15:0] ts,
                            input logic [31:0] ar, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [15:0] sh);
      write_register(REG_GAIN_DISTANCE, {16'd0, gd});
      write_register(REG_GAIN_BEARING, {16'd0, gb});
      write_register(REG_GAIN_FINAL_HEADING, {16'd0, gh});
      write_register(REG_TIME_STEP, {16'd0, ts});
      write_register(REG_ARRIVE_RADIUS, ar);
      write_register(REG_START_X, sx);
      write_register(REG_START_Y, sy);
      write_register(REG_START_HEADING, {16'd0, sh});
   endtask

   task automatic send_request(input logic [1:0] op, input logic [31:0] tx,
                               input logic [31:0] ty);
      req_type r;
      rsp_type e;
      r.op = op;
      r.target_x = tx;
      r.target_y = ty;
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 28) begin
         req_valid = 1'b0;
         req_data = $bits(req_type)'({$urandom, $urandom, $urandom});
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      predict_command(r, e);
      expected_responses.push_back(e);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_request(OP_STEP, 0, 0);
      send_request(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_SET_GOAL, 0, 0);
      send_request(OP_SET_GOAL, 32'h0005_0000, 32'hFFFD_0000);
      repeat (4) send_request(OP_STEP, 0, 0);
      send_request(OP_UNUSED, 0, 0);
      send_request(OP_LOAD_START, 0, 0);
      send_request(OP_SET_GOAL, 32'hFFF0_0000, 32'h0000_0001);
      repeat (3) send_request(OP_STEP, 0, 0);
      wait_idle();
   endtask

   task automatic test_extremes();
      write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd0,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(OP_LOAD_START, 0, 0);
      send_request(OP_SET_GOAL, 32'h8000_0000, 32'h8000_0000);
      repeat (3) send_request(OP_STEP, 0, 0);
      send_request(OP_SET_GOAL, 32'h7FFF_FFFF, 32'h8000_0000);
      repeat (2) send_request(OP_STEP, 0, 0);
      wait_idle();
      write_all(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 16'h8000);
      send_request(OP_LOAD_START, 0, 0);
      send_request(OP_SET_GOAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(OP_STEP, 0, 0);
      wait_idle();
      write_register(REG_ARRIVE_RADIUS, 0);
      send_request(OP_STEP, 0, 0);
      send_request(OP_SET_GOAL, 32'h8000_0000, 32'h8000_0000);
      send_request(OP_STEP, 0, 0);
      send_request(OP_UNUSED, 0, 0);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int near;
      logic [31:0] tx, ty;
      for (int phase = 0; phase < 11; phase++) begin
         no_gaps = (phase == 4);
         write_all(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000)),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000),
                   $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21),
                   $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21),
                   16'($urandom));
         send_request(OP_LOAD_START, $urandom, $urandom);
         for (int n = 0; n < 10; n++) begin
            near = $urandom_range(0, 3) != 0;
            tx = 32'(near ? start_px + $urandom_range(0, 1 << 22) - (1 << 21) : $urandom);
            ty = 32'(near ? start_py + $urandom_range(0, 1 << 22) - (1 << 21) : $urandom);
            send_request(OP_SET_GOAL, tx, ty);
            repeat ($urandom_range(1, 6)) send_request(OP_STEP, $urandom, $urandom);
            if ($urandom_range(0, 9) == 0) send_request(OP_UNUSED, $urandom, $urandom);
            if ($urandom_range(0, 14) == 0) send_request(OP_LOAD_START, $urandom, $urandom);
         end
         wait_idle();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_addr = REG_GAIN_DISTANCE;
      csr_wdata = '0;
      error_count = 0;
      no_gaps = 1'b0;
      apply_defaults();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_extremes();
      test_random_phases();
      wait_idle();
      if (error_count == 0) begin
         $display("move_to_pose_controller_core verification clean");
      end else begin
         $display("move_to_pose_controller_core verification failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !no_gaps && ($urandom_range(0, 99) < 28);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            e = expected_responses.pop_front();
            if (rsp_data.linear_velocity !== e.linear_velocity) begin
               $error("linear_velocity expected %0d actual %0d",
                      e.linear_velocity, rsp_data.linear_velocity);
               error_count++;
            end
            if (rsp_data.angular_velocity !== e.angular_velocity) begin
               $error("angular_velocity expected %0d actual %0d",
                      e.angular_velocity, rsp_data.angular_velocity);
               error_count++;
            end
            if (rsp_data.distance !== e.distance) begin
               $error("distance expected %0d actual %0d", e.distance, rsp_data.distance);
               error_count++;
            end
            if (rsp_data.arrived !== e.arrived) begin
               $error("arrived expected %0d actual %0d", e.arrived, rsp_data.arrived);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("move_to_pose_controller_core verification failed");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

`default_nettype wire
